// ----- design/vng_pkg.sv -----
// ----------------------------------------------------------------------------
// vng_pkg
// Shared widths, codes and the neighbor offset table of the voxel graph
// builder.
// ----------------------------------------------------------------------------
package vng_pkg;

  // Fixed field widths
  localparam int VALUE_W    = 8;
  localparam int COST_W     = 32;
  localparam int IDX_W      = 18;
  localparam int COORD_W    = 6;
  localparam int ENTRY_W    = IDX_W + 1;   // valid bit on top of a node index
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int DIM_RST    = 64;

  // Stream payload layout
  localparam int S_TDATA_W  = 40;
  localparam int M_FIELDS_W = 2 * IDX_W + 3 * COORD_W + COST_W;
  localparam int M_TDATA_W  = 88;
  localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd2;

  // Record kinds
  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_EDGE = 1'b1;

  // Raster-earlier neighbors
  localparam int NB_CNT     = 13;
  localparam int NB_CNT_W   = 4;
  localparam int MASK_EXT_W = 1 << NB_CNT_W;

  // Offset of one neighbor: minus or plus one along x and y, minus one along z
  typedef struct packed {
    logic xn;
    logic xp;
    logic yn;
    logic yp;
    logic zn;
  } nb_ofs_t;

  // Neighbor k in ascending raster order (previous plane first)
  function automatic nb_ofs_t nb_ofs(logic [NB_CNT_W-1:0] k);
    nb_ofs_t r;
    unique case (k)
      4'd0:    r = 5'b10101;
      4'd1:    r = 5'b00101;
      4'd2:    r = 5'b01101;
      4'd3:    r = 5'b10001;
      4'd4:    r = 5'b00001;
      4'd5:    r = 5'b01001;
      4'd6:    r = 5'b10011;
      4'd7:    r = 5'b00011;
      4'd8:    r = 5'b01011;
      4'd9:    r = 5'b10100;
      4'd10:   r = 5'b00100;
      4'd11:   r = 5'b01100;
      4'd12:   r = 5'b10000;
      default: r = 5'b00000;
    endcase
    return r;
  endfunction

endpackage

// ----- design/voxel_26_neighbor_graph_builder_core.sv -----
// ----------------------------------------------------------------------------
// voxel_26_neighbor_graph_builder_core
// Builds a 26-connected node and edge stream from voxels in raster order.
// ----------------------------------------------------------------------------
// Usage:
// - Slave stream takes one voxel per request, x fastest, then y, then z.
// - Each nonzero voxel yields a node record (tuser = 0) and then one edge
//   record (tuser = 1) per earlier foreground neighbor, ascending by index;
//   tlast marks the final record of that voxel. Background voxels yield none.
// - Configuration channel writes width, height and depth (indexes 0 to 2);
//   any such write restarts the volume. Write only while the block is idle.
// - A foreground voxel occupies the lookup sequencer for a start step,
//   thirteen neighbor steps (each reading the plane map where that neighbor
//   lies in the volume), a read drain and a closing step that writes its own
//   map entry; a background voxel is popped at once. The single-read plane
//   map is why the lookups run one after another.
// - The node record of a voxel is held until the first edge is found or the
//   scan ends.
// - A two-entry queue lets voxels be accepted while earlier ones are looked
//   up; an output register lets the scan run on while a record waits.
// - Receiver stall halts the scan in place; no record is dropped.
// - Reset returns dimensions to 64 (clamped to the maxima), position and
//   node numbering to zero. The plane map needs no clearing pass.
// ----------------------------------------------------------------------------
module voxel_26_neighbor_graph_builder_core import vng_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_DEPTH  = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] voxel_value, [39:8] voxel_cost
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [17:0] node_index, [35:18] neighbor_index, [41:36] coord_x,
  // [47:42] coord_y, [53:48] coord_z, [85:54] node_cost, [87:86] zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // [0] record_kind
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ZW     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int ITEM_W = 1 + XW + YW + ZW + IDX_W + COST_W + NB_CNT;
  localparam int COST_LSB = 2 * IDX_W + 3 * COORD_W;

  logic              q_push, q_full, q_pop, q_empty;
  logic [ITEM_W-1:0] q_wdata, q_head;

  vng_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  vng_queue #(
    .DW (ITEM_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  vng_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_head),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  // Track record framing for the checks below
  logic m_acc;
  logic after_last_q;

  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_last_q <= 1'b1;
    end else if (m_acc) begin
      after_last_q <= m_axis_tlast;
    end
  end

  // A voxel's records open with its node record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc && after_last_q |-> m_axis_tuser == KIND_NODE)
    else $error("record group does not open with a node record");

  // No second node record before the previous voxel closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc && !after_last_q |-> m_axis_tuser == KIND_EDGE)
    else $error("node record inside an unfinished record group");

  // Edge records carry no cost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_EDGE |->
      m_axis_tdata[COST_LSB +: COST_W] == '0)
    else $error("edge record with nonzero cost");

  // Queue is never pushed while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("voxel queue overflow");

endmodule

// ----- design/vng_ram.sv -----
// ----------------------------------------------------------------------------
// vng_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module vng_ram #(
  parameter int DW    = 19,
  parameter int DEPTH = 8192
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [DW-1:0]                             wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [DW-1:0]                             rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/vng_front.sv -----
// ----------------------------------------------------------------------------
// vng_front
// Accepts voxels, tracks the raster position and node numbering, and tags
// each voxel with foreground flag, node index and in-volume neighbor mask.
// ----------------------------------------------------------------------------
module vng_front import vng_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_DEPTH  = 64,
  parameter int ITEM_W     = 100
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [S_TDATA_W-1:0]  s_tdata_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output logic [ITEM_W-1:0]     q_data_o
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ZW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [XW-1:0] XLAST_RST = XW'(((DIM_RST > MAX_WIDTH) ? MAX_WIDTH : DIM_RST) - 1);
  localparam logic [YW-1:0] YLAST_RST =
    YW'(((DIM_RST > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RST) - 1);
  localparam logic [ZW-1:0] ZLAST_RST = ZW'(((DIM_RST > MAX_DEPTH) ? MAX_DEPTH : DIM_RST) - 1);

  // Clamp a written dimension into 1..maxv and return its last coordinate
  function automatic int dim_last(logic [CFG_DATA_W-1:0] v, int maxv);
    int e;
    e = int'(v);
    if (e < 1) begin
      e = 1;
    end else if (e > maxv) begin
      e = maxv;
    end
    return e - 1;
  endfunction

  logic [XW-1:0]    x_q, xlast_q;
  logic [YW-1:0]    y_q, ylast_q;
  logic [ZW-1:0]    z_q, zlast_q;
  logic [IDX_W-1:0] idx_q;
  logic             cfg_we;
  logic             accept;
  logic             fg;
  logic [NB_CNT-1:0] mask;
  nb_ofs_t          ofs;
  logic             x_end, y_end, z_end;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign s_tready_o  = !q_full_i;
  assign accept      = s_tvalid_i && !q_full_i;
  assign fg          = |s_tdata_i[VALUE_W-1:0];
  assign x_end       = (x_q == xlast_q);
  assign y_end       = (y_q == ylast_q);
  assign z_end       = (z_q == zlast_q);

  // Mark the earlier neighbors that lie inside the volume
  always_comb begin
    ofs = '0;
    for (int j = 0; j < NB_CNT; j++) begin
      ofs = nb_ofs(NB_CNT_W'(j));
      mask[j] = !(ofs.zn && (z_q == '0)) && !(ofs.yn && (y_q == '0)) &&
                !(ofs.yp && y_end) && !(ofs.xn && (x_q == '0)) &&
                !(ofs.xp && x_end);
    end
  end

  // Request into the queue
  assign q_push_o = accept;
  assign q_data_o = {mask, s_tdata_i[VALUE_W +: COST_W], idx_q, z_q, y_q, x_q, fg};

  // Dimensions and raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xlast_q <= XLAST_RST;
      ylast_q <= YLAST_RST;
      zlast_q <= ZLAST_RST;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      idx_q   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_WIDTH: begin
          xlast_q <= XW'(dim_last(cfg_data_i, MAX_WIDTH));
        end
        REG_HEIGHT: begin
          ylast_q <= YW'(dim_last(cfg_data_i, MAX_HEIGHT));
        end
        REG_DEPTH: begin
          zlast_q <= ZW'(dim_last(cfg_data_i, MAX_DEPTH));
        end
        default: begin
        end
      endcase
      // Restart the volume on any known register
      if (cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT ||
          cfg_index_i == REG_DEPTH) begin
        x_q   <= '0;
        y_q   <= '0;
        z_q   <= '0;
        idx_q <= '0;
      end
    end else if (accept) begin
      if (fg) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (x_end) begin
        x_q <= '0;
        if (y_end) begin
          y_q <= '0;
          if (z_end) begin
            z_q   <= '0;
            idx_q <= '0;
          end else begin
            z_q <= z_q + ZW'(1);
          end
        end else begin
          y_q <= y_q + YW'(1);
        end
      end else begin
        x_q <= x_q + XW'(1);
      end
    end
  end

endmodule

// ----- design/vng_queue.sv -----
// ----------------------------------------------------------------------------
// vng_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module vng_queue #(
  parameter int DW = 100
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] head_o,
  output logic          empty_o
);

  localparam int DEPTH = 2;

  logic [DW-1:0] ent_q [DEPTH];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = ent_q[rp_q];

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ----- design/vng_back.sv -----
// ----------------------------------------------------------------------------
// vng_back
// Looks up the earlier neighbors of each foreground voxel in the plane map,
// emits node and edge records, and writes each voxel's own map entry.
// ----------------------------------------------------------------------------
module vng_back import vng_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_DEPTH  = 64,
  parameter int ITEM_W     = 100
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  logic [ITEM_W-1:0]    q_data_i,
  output logic                 q_pop_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [M_TDATA_W-1:0] m_tdata_o,
  output logic                 m_tuser_o,
  output logic                 m_tlast_o
);

  localparam int XW          = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW          = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ZW          = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int PLANE_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAP_DEPTH   = 2 * PLANE_CELLS;
  localparam int AW          = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  localparam logic BK_IDLE = 1'b0;
  localparam logic BK_SCAN = 1'b1;

  // Map slot: plane parity, then row, then column
  function automatic logic [AW-1:0] map_addr(logic par, logic [YW-1:0] y, logic [XW-1:0] x);
    return (par ? AW'(PLANE_CELLS) : AW'(0)) + AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  // Head item fields
  logic [NB_CNT-1:0]     h_mask;
  logic [COST_W-1:0]     h_cost;
  logic [IDX_W-1:0]      h_idx;
  logic [ZW-1:0]         h_z;
  logic [YW-1:0]         h_y;
  logic [XW-1:0]         h_x;
  logic                  h_fg;
  logic [MASK_EXT_W-1:0] mask_ext;

  assign {h_mask, h_cost, h_idx, h_z, h_y, h_x, h_fg} = q_data_i;
  assign mask_ext = MASK_EXT_W'(h_mask);

  logic                 state_q, state_d;
  logic [NB_CNT_W-1:0]  k_q;
  logic                 rvld_q;
  logic                 pend_kind_q;
  logic [IDX_W-1:0]     pend_nbr_q;
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic                 out_kind_q;
  logic                 out_last_q;

  logic                 scan, out_free, arrive, move, issue, scan_done, push_edge;
  logic                 out_load, start;
  nb_ofs_t              ofs;
  logic [XW-1:0]        nx;
  logic [YW-1:0]        ny;
  logic                 nzp;
  logic [ENTRY_W-1:0]   rdata;
  logic [AW-1:0]        raddr, waddr;
  logic [ENTRY_W-1:0]   wdata;
  logic [COST_W-1:0]    rec_cost;

  // Neighbor address for the current step
  assign ofs   = nb_ofs(k_q);
  assign nx    = ofs.xn ? (h_x - XW'(1)) : (ofs.xp ? (h_x + XW'(1)) : h_x);
  assign ny    = ofs.yn ? (h_y - YW'(1)) : (ofs.yp ? (h_y + YW'(1)) : h_y);
  assign nzp   = h_z[0] ^ ofs.zn;
  assign raddr = map_addr(nzp, ny, nx);
  assign waddr = map_addr(h_z[0], h_y, h_x);
  assign wdata = h_fg ? {1'b1, h_idx} : '0;

  // Scan control: stall when a found edge or the closing record must load and the output is full
  assign scan      = (state_q == BK_SCAN);
  assign out_free  = !out_valid_q || m_tready_i;
  assign arrive    = rvld_q && rdata[IDX_W];
  assign move      = !arrive || out_free;
  assign issue     = scan && (k_q != NB_CNT_W'(NB_CNT)) && mask_ext[k_q] && move;
  assign scan_done = scan && (k_q == NB_CNT_W'(NB_CNT)) && !rvld_q && out_free;
  assign push_edge = scan && arrive && move;
  assign out_load  = push_edge || scan_done;
  assign start     = (state_q == BK_IDLE) && !q_empty_i && h_fg;

  // Pop background voxels at once, foreground voxels after their last record
  assign q_pop_o = ((state_q == BK_IDLE) && !q_empty_i && !h_fg) || scan_done;

  vng_ram #(
    .DW    (ENTRY_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (q_pop_o),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (start) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          state_d = BK_IDLE;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      k_q         <= '0;
      rvld_q      <= 1'b0;
      pend_kind_q <= KIND_NODE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !m_tready_i);
      if (start) begin
        k_q         <= '0;
        rvld_q      <= 1'b0;
        pend_kind_q <= KIND_NODE;
      end else if (scan && move) begin
        rvld_q <= issue;
        if (k_q != NB_CNT_W'(NB_CNT)) begin
          k_q <= k_q + NB_CNT_W'(1);
        end
        if (arrive) begin
          pend_kind_q <= KIND_EDGE;
        end
      end
    end
  end

  // Held record and output register payload
  assign rec_cost = (pend_kind_q == KIND_NODE) ? h_cost : '0;

  always_ff @(posedge clk_i) begin
    if (start) begin
      pend_nbr_q <= '0;
    end else if (push_edge) begin
      pend_nbr_q <= rdata[IDX_W-1:0];
    end
    if (out_load) begin
      out_data_q <= {M_PAD_W'(0), rec_cost, COORD_W'(h_z), COORD_W'(h_y), COORD_W'(h_x),
                     pend_nbr_q, h_idx};
      out_kind_q <= pend_kind_q;
      out_last_q <= scan_done;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

endmodule
